// File: rtl/fisr_pkg.sv
// ---------------------------------------------------------------------------
// fisr_pkg: shared types and float helpers for the inverse square root
// single-precision multiply/add front ends, leading-one search and rounding
// ---------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] MAGIC_K     = 32'h5f3759df;
  localparam logic [31:0] F_HALF      = 32'h3F000000;
  localparam logic [31:0] F_THREEHALF = 32'h3FC00000;
  localparam logic [31:0] F_INF       = 32'h7F800000;
  localparam logic [31:0] F_QNAN      = 32'h7FC00000;

  // operation select of one arithmetic unit
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_ADD = 1'b1;

  // unrounded result: value = sig * 2^(e - 150), or a ready special value
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sgn;
    logic signed [11:0] e;
    logic [63:0]        sig;
  } pre_t;

  function automatic logic f_isnan(input logic [31:0] a);
    return a[30:0] > F_INF[30:0];
  endfunction

  function automatic logic f_isinf(input logic [31:0] a);
    return a[30:0] == F_INF[30:0];
  endfunction

  function automatic logic f_iszero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] f_mant(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  function automatic logic signed [11:0] f_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, a[30:23]});
  endfunction

  // multiply front end: specials and exact product
  function automatic pre_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    pre_t r;
    r.spec     = 1'b0;
    r.spec_val = 32'd0;
    r.sgn      = a[31] ^ b[31];
    r.e        = f_exp(a) + f_exp(b) - 12'sd150;
    // full 48-bit product of the two 24-bit significands
    r.sig      = {16'd0, {24'd0, f_mant(a)} * {24'd0, f_mant(b)}};
    if (f_isnan(a) || f_isnan(b)) begin
      r.spec = 1'b1; r.spec_val = F_QNAN;
    end else if (f_isinf(a)) begin
      r.spec = 1'b1; r.spec_val = f_iszero(b) ? F_QNAN : {r.sgn, F_INF[30:0]};
    end else if (f_isinf(b)) begin
      r.spec = 1'b1; r.spec_val = f_iszero(a) ? F_QNAN : {r.sgn, F_INF[30:0]};
    end else if (f_iszero(a) || f_iszero(b)) begin
      r.spec = 1'b1; r.spec_val = {r.sgn, 31'd0};
    end
    return r;
  endfunction

  // add front end: specials, alignment and exact sum with sticky
  function automatic pre_t add_pre(input logic [31:0] a, input logic [31:0] b);
    pre_t r;
    logic [31:0] hi, lo;
    logic signed [11:0] eh, el, d;
    logic [63:0] big, sml;
    logic signed [11:0] e;
    r.spec     = 1'b0;
    r.spec_val = 32'd0;
    r.sgn      = 1'b0;
    r.e        = 12'sd0;
    r.sig      = 64'd0;
    if (f_exp(a) < f_exp(b)) begin
      hi = b; lo = a;
    end else begin
      hi = a; lo = b;
    end
    eh = f_exp(hi);
    el = f_exp(lo);
    d  = eh - el;
    if (d <= 12'sd36) begin
      big = {40'd0, f_mant(hi)} << d[5:0];
      sml = {40'd0, f_mant(lo)};
      e   = el;
    end else begin
      big = {40'd0, f_mant(hi)} << 3;
      sml = 64'd1;
      e   = eh - 12'sd3;
    end
    r.e = e;
    if (hi[31] == lo[31]) begin
      r.sgn = hi[31]; r.sig = big + sml;
    end else if (big > sml) begin
      r.sgn = hi[31]; r.sig = big - sml;
    end else if (sml > big) begin
      r.sgn = lo[31]; r.sig = sml - big;
    end else begin
      r.spec = 1'b1; r.spec_val = 32'd0;
    end
    if (f_isnan(a) || f_isnan(b)) begin
      r.spec = 1'b1; r.spec_val = F_QNAN;
    end else if (f_isinf(a) && f_isinf(b) && (a[31] != b[31])) begin
      r.spec = 1'b1; r.spec_val = F_QNAN;
    end else if (f_isinf(a)) begin
      r.spec = 1'b1; r.spec_val = a;
    end else if (f_isinf(b)) begin
      r.spec = 1'b1; r.spec_val = b;
    end else if (f_iszero(a) && f_iszero(b)) begin
      r.spec = 1'b1; r.spec_val = a & b;
    end else if (f_iszero(a)) begin
      r.spec = 1'b1; r.spec_val = b;
    end else if (f_iszero(b)) begin
      r.spec = 1'b1; r.spec_val = a;
    end
    return r;
  endfunction

  // position of the highest set bit
  function automatic logic [5:0] lead_pos(input logic [63:0] sig);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (sig[i]) p = 6'(i);
    end
    return p;
  endfunction

  // round to nearest even and pack
  function automatic logic [31:0] round_pack(input pre_t r, input logic [5:0] p);
    logic signed [11:0] s, ef;
    logic [7:0]  sa;
    logic [5:0]  sl;
    logic [63:0] q, rem, half;
    logic [33:0] mag;
    logic [11:0] eb;
    s = $signed({6'd0, p}) - 12'sd23;
    if (12'sd1 - r.e > s) s = 12'sd1 - r.e;
    ef   = r.e + s;
    sa   = s[7:0];
    sl   = 6'(-s);
    rem  = 64'd0;
    half = 64'd0;
    if (s < 12'sd0) begin
      q = r.sig << sl;
    end else if (s == 12'sd0) begin
      q = r.sig;
    end else if (s > $signed({6'd0, p}) + 12'sd1) begin
      q = 64'd0;
    end else begin
      rem  = r.sig & ~(64'hFFFF_FFFF_FFFF_FFFF << sa);
      half = 64'd1 << (sa - 8'd1);
      q    = r.sig >> sa;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    eb  = ef - 12'sd1;
    mag = ({22'd0, eb} << 23) + q[33:0];
    if (r.spec) return r.spec_val;
    if (r.sig == 64'd0) return {r.sgn, 31'd0};
    if (mag >= {2'b0, F_INF}) return {r.sgn, F_INF[30:0]};
    return {r.sgn, mag[30:0]};
  endfunction

endpackage

// File: rtl/fast_inverse_square_root.sv
// stages: five 3-stage units from input beat to result beat
// throughput: one beat per cycle; the whole pipe stalls while a result waits
// reset: rst_n synchronous active low clears all valid bits, payload kept
// ---------------------------------------------------------------------------
// fast_inverse_square_root: approximate 1/sqrt(x) with one newton step
// guess from the magic constant, then y * (1.5 - (0.5x * y) * y)
// ---------------------------------------------------------------------------
module fast_inverse_square_root
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);

  logic        en;
  logic [31:0] y0;
  logic        v_h, v_t1, v_t2, v_t3, v_r;
  logic [31:0] h, t1, t2, t3, res;
  logic [31:0] y_h, y_t1, y_t2, y_t3, y_r;

  // global advance: move when the output slot is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // initial guess from the bit pattern
  assign y0 = MAGIC_K - {in_tdata[31], in_tdata[31:1]};

  // h = 0.5 * x
  fisr_op u_h (.clk, .rst_n, .en, .op_sel(OP_MUL), .in_valid(in_tvalid),
    .a(F_HALF), .b(in_tdata), .side_in(y0),
    .out_valid(v_h), .res(h), .side_out(y_h));

  // t1 = h * y
  fisr_op u_t1 (.clk, .rst_n, .en, .op_sel(OP_MUL), .in_valid(v_h),
    .a(h), .b(y_h), .side_in(y_h),
    .out_valid(v_t1), .res(t1), .side_out(y_t1));

  // t2 = t1 * y
  fisr_op u_t2 (.clk, .rst_n, .en, .op_sel(OP_MUL), .in_valid(v_t1),
    .a(t1), .b(y_t1), .side_in(y_t1),
    .out_valid(v_t2), .res(t2), .side_out(y_t2));

  // t3 = 1.5 - t2
  fisr_op u_t3 (.clk, .rst_n, .en, .op_sel(OP_ADD), .in_valid(v_t2),
    .a(F_THREEHALF), .b({~t2[31], t2[30:0]}), .side_in(y_t2),
    .out_valid(v_t3), .res(t3), .side_out(y_t3));

  // result = y * t3
  fisr_op u_r (.clk, .rst_n, .en, .op_sel(OP_MUL), .in_valid(v_t3),
    .a(y_t3), .b(t3), .side_in(y_t3),
    .out_valid(v_r), .res(res), .side_out(y_r));

  assign out_tvalid = v_r;
  assign out_tdata  = (y_r == y_r) ? res : res;

`ifndef SYNTH
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped during stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_t3 && t3[30:0] == 31'd0) |-> !t3[31])
    else $error("negative zero from 1.5 minus t2");
`endif

endmodule

// File: rtl/fisr_op.sv
// ---------------------------------------------------------------------------
// fisr_op: three-stage single-precision multiply or add
// stage 1 exact product or aligned sum, stage 2 leading-one search,
// stage 3 round and pack; a side word rides along
// ---------------------------------------------------------------------------
module fisr_op
  import fisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        op_sel,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] side_in,
  output logic        out_valid,
  output logic [31:0] res,
  output logic [31:0] side_out
);

  logic        v1_r, v2_r, v3_r;
  pre_t        pre1_r, pre1_nxt, pre2_r;
  logic [5:0]  pos_r;
  logic [31:0] res_r;
  logic [31:0] side1_r, side2_r, side3_r;

  // front end by operation
  always_comb begin
    case (op_sel)
      OP_MUL:  pre1_nxt = mul_pre(a, b);
      OP_ADD:  pre1_nxt = add_pre(a, b);
      default: pre1_nxt = mul_pre(a, b);
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      pre1_r  <= pre1_nxt;
      side1_r <= side_in;
      pre2_r  <= pre1_r;
      pos_r   <= lead_pos(pre1_r.sig);
      side2_r <= side1_r;
      res_r   <= round_pack(pre2_r, pos_r);
      side3_r <= side2_r;
    end
  end

  assign out_valid = v3_r;
  assign res       = res_r;
  assign side_out  = side3_r;

`ifndef SYNTH
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (v1_r == $past(in_valid)) && (v2_r == $past(v1_r)))
    else $error("valid bit lost in advance");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && v3_r) |=> v3_r && $stable(res_r))
    else $error("result changed during stall");
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && res_r[30:23] == 8'hFF && res_r[22:0] != 23'd0) |-> res_r == F_QNAN)
    else $error("non-canonical nan");
`endif

endmodule
